// ===== hw/rtl/hsv_pkg.sv =====
// hsv_pkg: shared types and constants for the hsv threshold pixel vote block
// no dependencies

package hsv_pkg;

	typedef struct packed {
		logic       last_pixel;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [15:0] disqualified_total;
		logic [15:0] accepted_total;
		logic [15:0] qualified_total;
		logic [1:0]  verdict;
	} vote_t;

	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_QUAL  = 2'd1,
		CLS_ACC   = 2'd2,
		CLS_DISQ  = 2'd3
	} cls_t;

	// classified sample passed from front to back
	typedef struct packed {
		logic last_pixel;
		cls_t cls;
	} tok_t;

	localparam logic [1:0] VERDICT_QUAL = 2'd0;
	localparam logic [1:0] VERDICT_ACC  = 2'd1;
	localparam logic [1:0] VERDICT_DISQ = 2'd2;

	localparam logic [1:0] REG_QUAL_BOX  = 2'd0;
	localparam logic [1:0] REG_ACC_BOX   = 2'd1;
	localparam logic [1:0] REG_DISQ_CEIL = 2'd2;
	localparam logic [1:0] REG_STRIDE    = 2'd3;

	localparam logic [47:0] QUAL_BOX_RST  = 48'd280723345917475;
	localparam logic [47:0] ACC_BOX_RST   = 48'd231158667027215;
	localparam logic [23:0] DISQ_CEIL_RST = 24'd5258255;
	localparam logic [7:0]  STRIDE_RST    = 8'd5;

endpackage

// ===== hw/rtl/hsv_divider.sv =====
// hsv_divider: restoring divider, one quotient bit per cycle, quotient <= 8 bits
// depends on nothing

module hsv_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] num,
	input  logic [7:0]  den,
	output logic        busy,
	output logic        done,
	output logic [7:0]  quo
);
	logic [15:0] rem_q;
	logic [7:0]  den_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;

	assign trial = {rem_q, 1'b0} - {1'b0, den_q, 8'd0};
	assign busy  = busy_q;
	assign done  = busy_q && (cnt_q == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd8;
		end else if (busy_q) begin
			if (cnt_q == 4'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo   <= '0;
		end else if (busy_q && cnt_q != 4'd0) begin
			if (!trial[16]) rem_q <= trial[15:0];
			else rem_q <= {rem_q[14:0], 1'b0};
			quo <= {quo[6:0], ~trial[16]};
		end
	end
endmodule

// ===== hw/rtl/hsv_front.sv =====
// hsv_front: samples pixels, converts to hsv and classifies against the boxes
// depends on hsv_pkg, hsv_divider

module hsv_front
	import hsv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  pixel_t      pix,
	input  logic [47:0] qual_box,
	input  logic [47:0] acc_box,
	input  logic [23:0] disq_ceil,
	input  logic [7:0]  stride,
	output logic        tok_valid,
	output tok_t        tok,
	input  logic        tok_ready
);
	typedef enum logic [2:0] {F_IDLE, F_SAT, F_HUE, F_CLS, F_OUT} fstate_t;

	fstate_t     state_q, state_d;
	logic [7:0]  phase_q;
	logic [7:0]  r_q, g_q, b_q, mx_q, d_q, s_q, h_q;
	logic        last_q;
	logic        samp_q;
	tok_t        tok_q;
	logic [7:0]  mx, mn;
	logic [15:0] hnum;
	logic        div_start, div_busy, div_done;
	logic [15:0] div_num;
	logic [7:0]  div_den, div_quo;
	logic [7:0]  eff_stride, phase_nx;
	logic        accept;
	logic        in_q, in_a, in_d;

	assign accept = push && !full;
	assign eff_stride = (stride == 8'd0) ? 8'd1 : stride;
	assign phase_nx = (phase_q + 8'd1 >= eff_stride) ? 8'd0 : phase_q + 8'd1;

	always_comb begin
		mx = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx) mx = pix.blue;
		mn = pix.red;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
	end

	// half-degree hue numerator
	always_comb begin
		if (r_q >= mx_q) begin
			if (g_q >= b_q) hnum = 16'd30 * {8'd0, g_q - b_q};
			else hnum = 16'd180 * {8'd0, d_q} - 16'd30 * {8'd0, b_q - g_q};
		end else if (g_q >= mx_q) begin
			hnum = 16'd60 * {8'd0, d_q} + 16'd30 * {8'd0, b_q} - 16'd30 * {8'd0, r_q};
		end else begin
			hnum = 16'd120 * {8'd0, d_q} + 16'd30 * {8'd0, r_q} - 16'd30 * {8'd0, g_q};
		end
	end

	assign div_num = (state_q == F_SAT && !div_busy) ? 16'd255 * {8'd0, d_q} : hnum;
	assign div_den = (state_q == F_SAT && !div_busy) ? mx_q : d_q;

	hsv_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quo(div_quo)
	);

	assign in_q = h_q >= qual_box[7:0] && h_q <= qual_box[15:8] &&
		s_q >= qual_box[23:16] && s_q <= qual_box[31:24] &&
		mx_q >= qual_box[39:32] && mx_q <= qual_box[47:40];
	assign in_a = h_q >= acc_box[7:0] && h_q <= acc_box[15:8] &&
		s_q >= acc_box[23:16] && s_q <= acc_box[31:24] &&
		mx_q >= acc_box[39:32] && mx_q <= acc_box[47:40];
	assign in_d = h_q <= disq_ceil[7:0] && s_q <= disq_ceil[15:8] && mx_q <= disq_ceil[23:16];

	assign full = (state_q != F_IDLE);
	assign tok_valid = (state_q == F_OUT);
	assign tok = tok_q;

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		case (state_q)
			F_IDLE: if (accept) state_d = F_SAT;
			F_SAT: begin
				if (d_q == 8'd0) state_d = F_CLS;
				else if (!div_busy) div_start = 1'b1;
				else if (div_done) begin
					div_start = 1'b1;
					state_d = F_HUE;
				end
			end
			F_HUE: if (div_done) state_d = F_CLS;
			F_CLS: state_d = F_OUT;
			F_OUT: if (tok_ready) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) phase_q <= pix.last_pixel ? 8'd0 : phase_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r_q <= pix.red;
			g_q <= pix.green;
			b_q <= pix.blue;
			mx_q <= mx;
			d_q <= mx - mn;
			s_q <= '0;
			h_q <= '0;
			last_q <= pix.last_pixel;
			tok_q.cls <= CLS_NONE;
			tok_q.last_pixel <= pix.last_pixel;
			// skip hsv work on pixels off the sampling phase
			if (phase_q != 8'd0) d_q <= '0;
		end
		if (state_q == F_SAT && div_done) s_q <= div_quo;
		if (state_q == F_HUE && div_done) h_q <= div_quo;
		if (state_q == F_CLS) begin
			tok_q.last_pixel <= last_q;
			if (!samp_q) tok_q.cls <= CLS_NONE;
			else if (in_q) tok_q.cls <= CLS_QUAL;
			else if (in_a) tok_q.cls <= CLS_ACC;
			else if (in_d) tok_q.cls <= CLS_DISQ;
			else tok_q.cls <= CLS_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) samp_q <= (phase_q == 8'd0);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_q))
		else $error("front token changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> full)
		else $error("front took a pixel without going busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && pix.last_pixel |=> phase_q == 8'd0)
		else $error("phase not cleared at frame end");
endmodule

// ===== hw/rtl/hsv_back.sv =====
// hsv_back: token queue, saturating tallies and verdict output register
// depends on hsv_pkg

module hsv_back
	import hsv_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  tok_valid,
	input  tok_t  tok,
	output logic  tok_ready,
	output logic  empty,
	input  logic  pop,
	output vote_t vote
);
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	tok_t [1:0] fifo_q;
	logic [1:0] cnt_q;
	logic       wr_ptr_q, rd_ptr_q;
	logic [COUNT_WIDTH-1:0] qt_q, at_q, dt_q, qn, an, dn;
	logic       out_valid_q;
	vote_t      vote_q;
	logic       do_wr, do_rd;
	tok_t       head;

	assign tok_ready = (cnt_q != 2'd2);
	assign do_wr = tok_valid && tok_ready;
	assign head = fifo_q[rd_ptr_q];
	// a frame-end token waits until the output register is free
	assign do_rd = (cnt_q != 2'd0) && !(head.last_pixel && out_valid_q && !pop);
	assign empty = !out_valid_q;
	assign vote = vote_q;

	always_comb begin
		qn = qt_q;
		an = at_q;
		dn = dt_q;
		case (head.cls)
			CLS_QUAL: if (qt_q != CMAX) qn = qt_q + 1'b1;
			CLS_ACC:  if (at_q != CMAX) an = at_q + 1'b1;
			CLS_DISQ: if (dt_q != CMAX) dn = dt_q + 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			qt_q <= '0;
			at_q <= '0;
			dt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
				if (head.last_pixel) begin
					qt_q <= '0;
					at_q <= '0;
					dt_q <= '0;
				end else begin
					qt_q <= qn;
					at_q <= an;
					dt_q <= dn;
				end
			end
			if (do_rd && head.last_pixel) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) fifo_q[wr_ptr_q] <= tok;
		if (do_rd && head.last_pixel) begin
			if (qn >= an && qn >= dn) vote_q.verdict <= VERDICT_QUAL;
			else if (an >= dn) vote_q.verdict <= VERDICT_ACC;
			else vote_q.verdict <= VERDICT_DISQ;
			vote_q.qualified_total    <= 16'(qn);
			vote_q.accepted_total     <= 16'(an);
			vote_q.disqualified_total <= 16'(dn);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("token queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && head.last_pixel |=> qt_q == '0 && at_q == '0 && dt_q == '0)
		else $error("tallies not cleared after frame");
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(vote_q))
		else $error("result dropped while stalled");
endmodule

// ===== hw/rtl/hsv_threshold_pixel_vote.sv =====
// hsv_threshold_pixel_vote: top level, config registers, front and back parts
// depends on hsv_pkg, hsv_front, hsv_back
//
// Pixels come in on a queue-style port: an item transfers when push is high
// and full is low. The frame result (verdict and three totals) leaves on a
// second queue-style port: it is valid while empty is low and transfers when
// pop is high. Only the last pixel of a frame yields a result.
// A front unit takes one pixel at a time; colored samples use the shared
// one-bit-per-cycle divider for saturation and then hue, while off-phase
// and gray samples skip it. A two-entry token queue feeds the back unit
// that updates tallies, so the front keeps working while the result register
// waits for pop. Once that register and the queue are both full, full stays
// high until pop. Reset clears phase, tallies and queues and loads the
// default thresholds. Registers are written through cfg_we/cfg_idx/cfg_data
// only while idle; the user must keep to this, the block does not enforce it.

module hsv_threshold_pixel_vote
	import hsv_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  pixel_t      pixel,
	output logic        empty,
	input  logic        pop,
	output vote_t       result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [47:0] cfg_data
);
	logic [47:0] qual_box_q, acc_box_q;
	logic [23:0] disq_ceil_q;
	logic [7:0]  stride_q;
	logic        tok_valid, tok_ready;
	tok_t        tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qual_box_q  <= QUAL_BOX_RST;
			acc_box_q   <= ACC_BOX_RST;
			disq_ceil_q <= DISQ_CEIL_RST;
			stride_q    <= STRIDE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_QUAL_BOX:  qual_box_q  <= cfg_data;
				REG_ACC_BOX:   acc_box_q   <= cfg_data;
				REG_DISQ_CEIL: disq_ceil_q <= cfg_data[23:0];
				REG_STRIDE:    stride_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	hsv_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pix(pixel),
		.qual_box(qual_box_q), .acc_box(acc_box_q), .disq_ceil(disq_ceil_q),
		.stride(stride_q), .tok_valid(tok_valid), .tok(tok), .tok_ready(tok_ready)
	);

	hsv_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .tok_valid(tok_valid), .tok(tok),
		.tok_ready(tok_ready), .empty(empty), .pop(pop), .vote(result)
	);
endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for hsv_threshold_pixel_vote
// depends on hsv_pkg and the hsv_threshold_pixel_vote rtl
`timescale 1ns / 100ps

import hsv_pkg::*;

class vote_scoreboard;
	logic [47:0] qual_box, acc_box;
	logic [23:0] disq_ceil;
	logic [7:0]  stride, phase;
	int unsigned qual_cnt, acc_cnt, disq_cnt;
	vote_t       vote_q[$];
	int          mismatches;

	function new();
		qual_box = QUAL_BOX_RST;
		acc_box = ACC_BOX_RST;
		disq_ceil = DISQ_CEIL_RST;
		stride = STRIDE_RST;
		phase = 0;
		qual_cnt = 0;
		acc_cnt = 0;
		disq_cnt = 0;
		mismatches = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [47:0] val);
		case (idx)
			REG_QUAL_BOX:  qual_box = val;
			REG_ACC_BOX:   acc_box = val;
			REG_DISQ_CEIL: disq_ceil = val[23:0];
			REG_STRIDE:    stride = val[7:0];
			default: ;
		endcase
	endfunction

	function bit in_box(logic [47:0] box, int h, int s, int v);
		return h >= box[7:0] && h <= box[15:8] && s >= box[23:16] && s <= box[31:24]
			&& v >= box[39:32] && v <= box[47:40];
	endfunction

	function void note_pixel(pixel_t px);
		int r, g, b, mx, mn, d, h, s, num, lim;
		vote_t res;
		r = px.red;
		g = px.green;
		b = px.blue;
		lim = (stride == 0) ? 1 : stride;
		if (phase == 0) begin
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			h = 0;
			s = 0;
			if (d != 0) begin
				s = (255 * d) / mx;
				if (r >= mx) num = (g >= b) ? 30 * (g - b) : 180 * d - 30 * (b - g);
				else if (g >= mx) num = 60 * d + 30 * b - 30 * r;
				else num = 120 * d + 30 * r - 30 * g;
				h = num / d;
			end
			if (in_box(qual_box, h, s, mx)) begin
				if (qual_cnt < 65535) qual_cnt++;
			end else if (in_box(acc_box, h, s, mx)) begin
				if (acc_cnt < 65535) acc_cnt++;
			end else if (h <= disq_ceil[7:0] && s <= disq_ceil[15:8]
					&& mx <= disq_ceil[23:16]) begin
				if (disq_cnt < 65535) disq_cnt++;
			end
		end
		phase = (phase + 1 >= lim) ? 8'd0 : phase + 8'd1;
		if (px.last_pixel) begin
			if (qual_cnt >= acc_cnt && qual_cnt >= disq_cnt) res.verdict = VERDICT_QUAL;
			else if (acc_cnt >= disq_cnt) res.verdict = VERDICT_ACC;
			else res.verdict = VERDICT_DISQ;
			res.qualified_total = 16'(qual_cnt);
			res.accepted_total = 16'(acc_cnt);
			res.disqualified_total = 16'(disq_cnt);
			vote_q.push_back(res);
			qual_cnt = 0;
			acc_cnt = 0;
			disq_cnt = 0;
			phase = 0;
		end
	endfunction

	function void check_vote(vote_t got);
		vote_t exp;
		if (vote_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h", got);
			return;
		end
		exp = vote_q.pop_front();
		if (got.verdict !== exp.verdict || got.qualified_total !== exp.qualified_total
				|| got.accepted_total !== exp.accepted_total
				|| got.disqualified_total !== exp.disqualified_total) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp v=%0d q=%0d a=%0d d=%0d got v=%0d q=%0d a=%0d d=%0d",
					exp.verdict, exp.qualified_total, exp.accepted_total,
					exp.disqualified_total, got.verdict, got.qualified_total,
					got.accepted_total, got.disqualified_total);
		end
	endfunction
endclass

module tb;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	pixel_t      pixel = '0;
	logic        empty;
	logic        pop = 0;
	vote_t       result;
	logic        cfg_we = 0;
	logic [1:0]  cfg_idx = '0;
	logic [47:0] cfg_data = '0;

	vote_scoreboard sb = new();
	int  idle_cycles = 0;
	bit  calm = 0;
	bit  hold_rx = 0;

	hsv_threshold_pixel_vote u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pixel(pixel),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver side: random pop, checked on transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) sb.check_vote(result);
			pop <= !hold_rx && (calm || $urandom_range(99) >= 19);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// push stays high on return so that the next transfer can follow directly
	task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic lst);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.last_pixel = lst;
		while (!calm && $urandom_range(99) < 19) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		pixel <= px;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_pixel(px);
	endtask

	task send_random(int n, int frame_max);
		int left;
		left = $urandom_range(frame_max, 1);
		repeat (n) begin
			left--;
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), left == 0);
			if (left == 0) left = $urandom_range(frame_max, 1);
		end
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
	endtask

	task drain();
		push <= 0;
		while (sb.vote_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [47:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// random box with random ordered bounds per channel
	function logic [47:0] rand_box();
		logic [47:0] bx;
		logic [7:0] a, c;
		for (int k = 0; k < 3; k++) begin
			a = 8'($urandom);
			c = 8'($urandom);
			if (a > c) begin
				bx[16*k +: 8] = c;
				bx[16*k+8 +: 8] = a;
			end else begin
				bx[16*k +: 8] = a;
				bx[16*k+8 +: 8] = c;
			end
		end
		return bx;
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: gray, primaries, hue ties, extremes, default thresholds
		send_pixel(0, 0, 0, 0);
		send_pixel(255, 255, 255, 0);
		send_pixel(255, 0, 0, 0);
		send_pixel(0, 255, 0, 0);
		send_pixel(0, 0, 255, 0);
		send_pixel(255, 255, 0, 0);
		send_pixel(0, 255, 255, 0);
		send_pixel(255, 0, 255, 0);
		send_pixel(255, 1, 0, 0);
		send_pixel(128, 128, 127, 0);
		send_pixel(1, 0, 0, 1);
		send_pixel(200, 100, 50, 1);
		drain();
		write_reg(REG_STRIDE, 48'd0);
		write_reg(REG_QUAL_BOX, 48'hFFFF_FF00_B300);
		send_pixel(255, 0, 0, 0);
		send_pixel(0, 0, 0, 0);
		send_pixel(0, 0, 255, 1);
		drain();
		write_reg(REG_QUAL_BOX, '0);
		write_reg(REG_ACC_BOX, '0);
		write_reg(REG_DISQ_CEIL, 48'hFF_FFFF);
		write_reg(REG_STRIDE, 48'd1);
		send_pixel(10, 20, 30, 0);
		send_pixel(0, 0, 0, 1);
		drain();

		// random phases over settings, extremes included
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: write_reg(REG_STRIDE, 48'd255);
				1: write_reg(REG_STRIDE, 48'd1);
				2: begin
					write_reg(REG_QUAL_BOX, 48'hFFFF_FFFF_FFFF);
					write_reg(REG_ACC_BOX, '0);
				end
				default: begin
					write_reg(REG_QUAL_BOX, rand_box());
					write_reg(REG_ACC_BOX, rand_box());
					write_reg(REG_DISQ_CEIL, 48'($urandom));
					write_reg(REG_STRIDE, 48'($urandom_range(4, 0)));
				end
			endcase
			calm = (ph == 4);
			if (ph == 5) begin
				fork
					begin
						hold_rx = 1;
						repeat (600) @(posedge clk);
						hold_rx = 0;
					end
					send_random(190, 4);
				join
			end else begin
				send_random(190, ph == 0 ? 600 : 30);
			end
			drain();
		end

		if (sb.mismatches == 0 && sb.vote_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
